// File: sv/splat_depth_sorter_macros.svh
// Assertion helpers for the splat depth sorter.
`ifndef SPLAT_DEPTH_SORTER_MACROS_SVH
`define SPLAT_DEPTH_SORTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/sds_pkg.sv
`default_nettype none
package sds_pkg;

	// Field widths
	localparam int ID_W     = 16;
	localparam int POS_W    = 32;
	localparam int COEF_W   = 32;
	localparam int DEPTH_W  = 40;
	localparam int PROD_W   = 2 * COEF_W;
	localparam int SUM_W    = PROD_W + 2;
	localparam int FRAC_W   = 16;
	localparam int CFG_IDX_W = 2;

	// Default number of cells in the sorted chain
	localparam int CAPACITY_DEF = 256;

	// Register reset values
	localparam logic signed [COEF_W-1:0] COEF_X_RST = 32'sd0;
	localparam logic signed [COEF_W-1:0] COEF_Y_RST = 32'sd0;
	localparam logic signed [COEF_W-1:0] COEF_Z_RST = 32'sd65536;
	localparam logic signed [COEF_W-1:0] OFFSET_RST = 32'sd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_X       = 2'd0,
		REG_COEF_Y       = 2'd1,
		REG_COEF_Z       = 2'd2,
		REG_DEPTH_OFFSET = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_POP  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STAT_LOADED  = 2'd0,
		STAT_POPPED  = 2'd1,
		STAT_DROPPED = 2'd2,
		STAT_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SUM,
		S_SAT,
		S_EXEC
	} state_t;

	// Request word
	typedef struct packed {
		action_t                   action;
		logic [ID_W-1:0]           splat_id;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [POS_W-1:0]   pos_z;
	} req_t;

	// Response word
	typedef struct packed {
		status_t                   status;
		logic [ID_W-1:0]           out_id;
		logic signed [DEPTH_W-1:0] out_depth;
		logic                      last;
	} rsp_t;

	// One stored entry
	typedef struct packed {
		logic signed [DEPTH_W-1:0] depth;
		logic [ID_W-1:0]           id;
	} entry_t;

	// Command broadcast to every cell
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t ent;
	} chain_cmd_t;

	// Chain status back to the controller
	typedef struct packed {
		logic   empty;
		logic   full;
		logic   one_left;
		entry_t head;
	} chain_stat_t;

endpackage
`default_nettype wire

// File: sv/sds_cell.sv
`default_nettype none
module sds_cell
	import sds_pkg::*;
(
	input  wire logic       clk,
	input  wire chain_cmd_t cmd,
	input  wire logic       valid,
	input  wire entry_t     left,
	input  wire logic       left_ahead,
	input  wire entry_t     right,
	output entry_t          entry,
	output logic            ahead
);

	entry_t entry_q;

	// New entry sorts ahead of this one; an empty cell counts as +infinity
	always_comb begin
		ahead = !valid
			|| ($signed(cmd.ent.depth) < $signed(entry_q.depth))
			|| ((cmd.ent.depth == entry_q.depth) && (cmd.ent.id < entry_q.id));
	end

	// Insert: shift right past the insert point; pop: shift left
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (left_ahead) begin
				entry_q <= left;
			end else if (ahead) begin
				entry_q <= cmd.ent;
			end
		end else if (cmd.pop) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

// File: sv/sds_chain.sv
`default_nettype none
module sds_chain
	import sds_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire chain_cmd_t cmd,
	output chain_stat_t     stat
);

	localparam int OCC_W = $clog2(CAPACITY + 1);

	logic [OCC_W-1:0] occ_q;
	entry_t           ent  [CAPACITY];
	logic             bef  [CAPACITY];

	// Row of cells; cell 0 holds the smallest entry
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_ent;
		logic   left_bef;
		entry_t right_ent;
		logic   cell_valid;

		if (i == 0) begin : g_first
			assign left_ent = '0;
			assign left_bef = 1'b0;
		end else begin : g_mid
			assign left_ent = ent[i-1];
			assign left_bef = bef[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_ent = ent[i];
		end else begin : g_inner
			assign right_ent = ent[i+1];
		end

		assign cell_valid = occ_q > OCC_W'(i);

		sds_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.valid      (cell_valid),
			.left       (left_ent),
			.left_ahead (left_bef),
			.right      (right_ent),
			.entry      (ent[i]),
			.ahead      (bef[i])
		);
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.push) begin
			occ_q <= occ_q + OCC_W'(1);
		end else if (cmd.pop) begin
			occ_q <= occ_q - OCC_W'(1);
		end
	end

	assign stat.empty    = occ_q == '0;
	assign stat.full     = occ_q == OCC_W'(CAPACITY);
	assign stat.one_left = occ_q == OCC_W'(1);
	assign stat.head     = ent[0];

endmodule
`default_nettype wire

// File: sv/sds_depth.sv
`default_nettype none
module sds_depth
	import sds_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic signed [COEF_W-1:0]  coef_x,
	input  wire logic signed [COEF_W-1:0]  coef_y,
	input  wire logic signed [COEF_W-1:0]  coef_z,
	input  wire logic signed [COEF_W-1:0]  depth_offset,
	input  wire logic signed [POS_W-1:0]   pos_x,
	input  wire logic signed [POS_W-1:0]   pos_y,
	input  wire logic signed [POS_W-1:0]   pos_z,
	output logic signed [DEPTH_W-1:0]      depth
);

	localparam int SH_W = SUM_W - FRAC_W;
	localparam int T_W  = SH_W + 1;
	localparam int HI_W = T_W - DEPTH_W + 1;

	localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
	localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

	logic signed [PROD_W-1:0]  prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [SUM_W-1:0]   sum_s2;
	logic signed [DEPTH_W-1:0] depth_s3;
	logic signed [SH_W-1:0]    shifted;
	logic signed [T_W-1:0]     total;
	logic [HI_W-1:0]           total_hi;

	// Stage 1: three 32x32 products, Q32.32
	always_ff @(posedge clk) begin
		prod_x_s1 <= coef_x * pos_x;
		prod_y_s1 <= coef_y * pos_y;
		prod_z_s1 <= coef_z * pos_z;
	end

	// Stage 2: exact sum of the products
	always_ff @(posedge clk) begin
		sum_s2 <= SUM_W'(prod_x_s1) + SUM_W'(prod_y_s1) + SUM_W'(prod_z_s1);
	end

	// Floor to Q.16, add the offset, saturate to 40 bits
	always_comb begin
		shifted  = sum_s2[SUM_W-1:FRAC_W];
		total    = T_W'(shifted) + T_W'(depth_offset);
		total_hi = total[T_W-1:DEPTH_W-1];
	end

	// Stage 3
	always_ff @(posedge clk) begin
		if (total_hi != '0 && total_hi != '1) begin
			depth_s3 <= total[T_W-1] ? DEPTH_MIN : DEPTH_MAX;
		end else begin
			depth_s3 <= total[DEPTH_W-1:0];
		end
	end

	assign depth = depth_s3;

endmodule
`default_nettype wire

// File: sv/splat_depth_sorter.sv
// A load passes the captured request through the 3-stage depth pipeline and then
// the chain update; a pop goes straight to the chain update. The controller works
// on one word at a time and accepts no new word until the single chain update for
// the current word has fired, which waits until the output register is free.
// Reset (arst_n low, asynchronous): store empty, registers at their defaults,
// no response pending. Cell contents are not cleared.
`default_nettype none
module splat_depth_sorter
	import sds_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire req_t                 req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rsp_t                      rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COEF_W-1:0]    cfg_data
);

	`include "splat_depth_sorter_macros.svh"

	state_t      state_q, state_d;
	req_t        req_q;
	rsp_t        rsp_q, rsp_d;
	logic        rsp_valid_q;
	logic        out_free;
	logic        exec_fire;
	logic        accept;
	chain_cmd_t  cmd;
	chain_stat_t stat;

	logic signed [COEF_W-1:0]  coef_x_q, coef_y_q, coef_z_q, offset_q;
	logic signed [DEPTH_W-1:0] depth;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q <= COEF_X_RST;
			coef_y_q <= COEF_Y_RST;
			coef_z_q <= COEF_Z_RST;
			offset_q <= OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_COEF_X:       coef_x_q <= cfg_data;
				REG_COEF_Y:       coef_y_q <= cfg_data;
				REG_COEF_Z:       coef_z_q <= cfg_data;
				REG_DEPTH_OFFSET: offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request capture
	assign accept = req_valid && req_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	// Depth pipeline runs freely off the captured request
	sds_depth u_depth (
		.clk          (clk),
		.coef_x       (coef_x_q),
		.coef_y       (coef_y_q),
		.coef_z       (coef_z_q),
		.depth_offset (offset_q),
		.pos_x        (req_q.pos_x),
		.pos_y        (req_q.pos_y),
		.pos_z        (req_q.pos_z),
		.depth        (depth)
	);

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = (req.action == ACT_POP) ? S_EXEC : S_MUL;
				end
			end
			S_MUL:  state_d = S_SUM;
			S_SUM:  state_d = S_SAT;
			S_SAT:  state_d = S_EXEC;
			S_EXEC: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		out_free  = !rsp_valid_q || rsp_ready;
		req_ready = state_q == S_IDLE;
		exec_fire = (state_q == S_EXEC) && out_free;
		cmd.ent.depth = depth;
		cmd.ent.id    = req_q.splat_id;
		cmd.push = exec_fire && (req_q.action == ACT_LOAD) && !stat.full;
		cmd.pop  = exec_fire && (req_q.action == ACT_POP) && !stat.empty;
	end

	// Sorted chain
	sds_chain #(
		.CAPACITY (CAPACITY)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	// Response word
	always_comb begin
		rsp_d = '0;
		if (req_q.action == ACT_LOAD) begin
			rsp_d.status = stat.full ? STAT_DROPPED : STAT_LOADED;
		end else if (stat.empty) begin
			rsp_d.status = STAT_EMPTY;
		end else begin
			rsp_d.status    = STAT_POPPED;
			rsp_d.out_id    = stat.head.id;
			rsp_d.out_depth = stat.head.depth;
			rsp_d.last      = stat.one_left;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	`SDS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q == S_MUL || state_q == S_EXEC,
		"accepted word did not start work")
	`SDS_ASSERT_NOW(a_no_push_when_full, cmd.push, !stat.full,
		"insert issued into a full chain")
	`SDS_ASSERT_NOW(a_no_pop_when_empty, cmd.pop, !stat.empty,
		"pop issued on an empty chain")
	`SDS_ASSERT_NEXT(a_exec_gives_rsp, exec_fire, rsp_valid_q && state_q == S_IDLE,
		"finished word produced no response")

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
module tb_top;
	import sds_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam logic signed [67:0] DEPTH_TOP    = 68'sh7F_FFFF_FFFF;
	localparam logic signed [67:0] DEPTH_BOTTOM = -68'sh80_0000_0000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_t       req = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_t       rsp;
	logic       cfg_we = 1'b0;
	cfg_reg_t   cfg_index = REG_COEF_X;
	logic [COEF_W-1:0] cfg_data = '0;

	// Local copy of the view-z row, updated as registers are written
	logic signed [COEF_W-1:0] view_wx = COEF_X_RST;
	logic signed [COEF_W-1:0] view_wy = COEF_Y_RST;
	logic signed [COEF_W-1:0] view_wz = COEF_Z_RST;
	logic signed [COEF_W-1:0] view_off = OFFSET_RST;

	entry_t near_to_far[$];    // predicted store contents, nearest first
	req_t   outgoing_reqs[$];  // words waiting for the driver
	rsp_t   awaited[$];        // predicted responses, oldest first
	rsp_t   oldest_rsp;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int words_seen = 0;
	int settings = 0;
	int cycles = 0;
	int tally [4] = '{default: 0};

	splat_depth_sorter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Exact dot product plus offset, floored to Q24.16, then clamped to 40 bits
	function automatic logic [DEPTH_W-1:0] view_depth_of(logic signed [POS_W-1:0] x,
			logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
		logic signed [67:0] acc;
		acc = 68'(view_wx) * 68'(x) + 68'(view_wy) * 68'(y) + 68'(view_wz) * 68'(z)
			+ (68'(view_off) <<< FRAC_W);
		acc = acc >>> FRAC_W;
		if (acc > DEPTH_TOP) acc = DEPTH_TOP;
		if (acc < DEPTH_BOTTOM) acc = DEPTH_BOTTOM;
		return acc[DEPTH_W-1:0];
	endfunction

	// Apply one accepted word to the predicted store and return its response
	function automatic rsp_t depth_sort_answer(req_t r);
		rsp_t   a;
		entry_t e;
		int     k;
		a = '0;
		if (r.action == ACT_LOAD) begin
			if (near_to_far.size() >= CAPACITY_DEF) begin
				a.status = STAT_DROPPED;
			end else begin
				e.depth = view_depth_of(r.pos_x, r.pos_y, r.pos_z);
				e.id = r.splat_id;
				// goes after every entry it does not sort strictly ahead of
				k = 0;
				while (k < near_to_far.size() &&
						!($signed(e.depth) < $signed(near_to_far[k].depth) ||
						(e.depth == near_to_far[k].depth && e.id < near_to_far[k].id)))
					k++;
				near_to_far.insert(k, e);
				a.status = STAT_LOADED;
			end
		end else if (near_to_far.size() == 0) begin
			a.status = STAT_EMPTY;
		end else begin
			e = near_to_far.pop_front();
			a.status = STAT_POPPED;
			a.out_id = e.id;
			a.out_depth = e.depth;
			a.last = (near_to_far.size() == 0);
		end
		return a;
	endfunction

	function automatic req_t make_load(logic [ID_W-1:0] id, logic [POS_W-1:0] x,
			logic [POS_W-1:0] y, logic [POS_W-1:0] z);
		req_t r;
		r.action = ACT_LOAD;
		r.splat_id = id;
		r.pos_x = x;
		r.pos_y = y;
		r.pos_z = z;
		return r;
	endfunction

	// Pop with junk in the fields it should ignore
	function automatic req_t make_pop();
		req_t r;
		r.action = ACT_POP;
		r.splat_id = ID_W'($urandom());
		r.pos_x = $urandom();
		r.pos_y = $urandom();
		r.pos_z = $urandom();
		return r;
	endfunction

	// Coordinate or weight: full range, small, corner values, or whole steps for ties
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 2097152) - 1048576;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_0000;
					default: return 32'h0;
				endcase
			end
			default: return $urandom_range(0, 3) << FRAC_W;
		endcase
	endfunction

	function automatic logic [ID_W-1:0] rand_id();
		if ($urandom_range(0, 1)) return ID_W'($urandom());
		return ID_W'($urandom_range(0, 7));
	endfunction

	task automatic set_view_row(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] cz, input logic [31:0] off);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_COEF_X;
		cfg_data <= cx;
		@(posedge clk);
		cfg_index <= REG_COEF_Y;
		cfg_data <= cy;
		@(posedge clk);
		cfg_index <= REG_COEF_Z;
		cfg_data <= cz;
		@(posedge clk);
		cfg_index <= REG_DEPTH_OFFSET;
		cfg_data <= off;
		@(posedge clk);
		cfg_we <= 1'b0;
		view_wx = cx;
		view_wy = cy;
		view_wz = cz;
		view_off = off;
		settings++;
		@(negedge clk);
	endtask

	// Block until every word is out and answered, then let the pipeline settle
	task automatic wait_drained();
		do @(negedge clk);
		while (outgoing_reqs.size() != 0 || req_valid || awaited.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	// Append one word to the driver's list
	task automatic enqueue_word(input req_t r);
		outgoing_reqs.insert(outgoing_reqs.size(), r);
	endtask

	// Bursts of loads or pops with random content
	task automatic push_random(input int count);
		int n;
		int len;
		bit loads;
		n = 0;
		while (n < count) begin
			len = $urandom_range(1, 10);
			if (len > count - n) len = count - n;
			loads = ($urandom_range(99) < 60);
			repeat (len) begin
				if (loads)
					enqueue_word(make_load(rand_id(), rand_coord(), rand_coord(),
						rand_coord()));
				else
					enqueue_word(make_pop());
			end
			n += len;
		end
	endtask

	task automatic flag_bad(input string msg);
		if (mismatches < 10) $display("tb_top: mismatch: %s", msg);
		mismatches++;
	endtask

	// Driver: predict on acceptance, then offer the next word or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) awaited.insert(awaited.size(), depth_sort_answer(req));
			if (!req_valid || req_ready) begin
				if (outgoing_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= outgoing_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted response word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				words_seen++;
				tally[rsp.status]++;
				if (awaited.size() == 0) begin
					flag_bad($sformatf("response %0d arrived with nothing outstanding",
						words_seen));
				end else begin
					oldest_rsp = awaited.pop_front();
					if (rsp.status !== oldest_rsp.status || rsp.out_id !== oldest_rsp.out_id ||
							rsp.out_depth !== oldest_rsp.out_depth ||
							rsp.last !== oldest_rsp.last)
						flag_bad($sformatf(
							"response %0d: got %s id %h depth %0d last %b, want %s id %h depth %0d last %b",
							words_seen, rsp.status.name(), rsp.out_id, $signed(rsp.out_depth),
							rsp.last, oldest_rsp.status.name(), oldest_rsp.out_id,
							$signed(oldest_rsp.out_depth), oldest_rsp.last));
				end
			end
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: timeout after %0d cycles, %0d words outstanding", cycles,
				awaited.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		int p;
		int k;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Default row: depth equals z. Empty pop, corners, ties on depth and id.
		enqueue_word(make_pop());
		enqueue_word(make_load(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		enqueue_word(make_load(16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		enqueue_word(make_load(16'd5, 32'h0, 32'h0, 32'h0001_0000));
		enqueue_word(make_load(16'd3, 32'h0, 32'h0, 32'h0001_0000));
		enqueue_word(make_load(16'd3, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000));
		repeat (6) enqueue_word(make_pop());
		wait_drained();

		// Largest weights and offset: saturation at both ends
		set_view_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		enqueue_word(make_load(16'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		enqueue_word(make_load(16'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		enqueue_word(make_load(16'd4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
		repeat (3) enqueue_word(make_pop());
		wait_drained();

		// Most negative weights and offset
		set_view_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		enqueue_word(make_load(16'd9, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		enqueue_word(make_load(16'd8, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		enqueue_word(make_pop());
		enqueue_word(make_pop());
		wait_drained();

		// Fill past capacity, then drain past empty
		send_idle_pct = 13;
		stall_pct = 13;
		set_view_row($urandom_range(0, 262144) - 131072, $urandom_range(0, 262144) - 131072,
			$urandom_range(0, 262144) - 131072, $urandom());
		for (k = 0; k < CAPACITY_DEF + 2; k++)
			enqueue_word(make_load(ID_W'($urandom_range(0, 63)), $urandom_range(0, 15) << 16,
				$urandom_range(0, 15) << 16, $urandom_range(0, 15) << 16));
		for (k = 0; k < CAPACITY_DEF + 3; k++) enqueue_word(make_pop());
		wait_drained();

		// Random traffic under each idling pattern and several view rows
		for (p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 68; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 68; end
				default: begin send_idle_pct = 13; stall_pct = 13; end
			endcase
			case ((p + p / 4) % 4)
				0: set_view_row($urandom_range(0, 262144) - 131072,
					$urandom_range(0, 262144) - 131072, $urandom_range(0, 262144) - 131072,
					$urandom_range(0, 262144) - 131072);
				1: set_view_row($urandom(), $urandom(), $urandom(), $urandom());
				2: set_view_row(32'h8000_0000, 32'h7FFF_FFFF, rand_coord(), 32'h8000_0000);
				default: set_view_row(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			endcase
			push_random(24);
			// hold off mid-phase until everything is answered
			wait_drained();
			push_random(24);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		$display("tb_top: %0d words checked: %0d loaded, %0d popped, %0d dropped full, %0d empty",
			words_seen, tally[STAT_LOADED], tally[STAT_POPPED], tally[STAT_DROPPED],
			tally[STAT_EMPTY]);
		$display("tb_top: %0d view-row settings applied, %0d mismatches", settings, mismatches);
		if (mismatches == 0 && awaited.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
